[design/bdr_pkg.sv]
// ----------------------------------------------------------------------------
// bdr_pkg
// Shared types and constants for the button debounce / repeat / combo block.
// ----------------------------------------------------------------------------
`default_nettype none

package bdr_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_DEBOUNCE_TIME   = 3'd0,
    REG_PAIR_HOLD_TIME  = 3'd1,
    REG_RESET_HOLD_TIME = 3'd2,
    REG_REPEAT_DELAY    = 3'd3,
    REG_REPEAT_PERIOD   = 3'd4
  } reg_idx_t;

  // combo status codes
  localparam logic [1:0] COMBO_NONE  = 2'd0;
  localparam logic [1:0] COMBO_PAIR  = 2'd1;
  localparam logic [1:0] COMBO_RESET = 2'd2;

  localparam int CFG_BITS = 32;

  // reset values of the registers
  localparam logic [15:0] DEBOUNCE_TIME_RST   = 16'd15;
  localparam logic [31:0] PAIR_HOLD_TIME_RST  = 32'd3000;
  localparam logic [31:0] RESET_HOLD_TIME_RST = 32'd10000;
  localparam logic [15:0] REPEAT_DELAY_RST    = 16'd400;
  localparam logic [15:0] REPEAT_PERIOD_RST   = 16'd140;

  typedef struct packed {
    logic [15:0] debounce_time;
    logic [31:0] pair_hold_time;
    logic [31:0] reset_hold_time;
    logic [15:0] repeat_delay;
    logic [15:0] repeat_period;
  } cfg_t;

endpackage

`default_nettype wire

[design/bdr_if.sv]
// ----------------------------------------------------------------------------
// bdr_in_if / bdr_out_if
// Valid/ready channels for scan ticks and per-tick results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdr_in_if #(
  parameter int NUM_BUTTONS = 6
);
  logic                   valid;
  logic                   ready;
  logic [NUM_BUTTONS-1:0] raw_buttons;
  logic [31:0]            now_ms;
  logic                   host_ready;

  modport source (output valid, output raw_buttons, output now_ms, output host_ready,
                  input ready);
  modport sink   (input valid, input raw_buttons, input now_ms, input host_ready,
                  output ready);
endinterface

interface bdr_out_if #(
  parameter int NUM_BUTTONS = 6
);
  logic                   valid;
  logic                   ready;
  logic [NUM_BUTTONS-1:0] consumer_bits;
  logic [1:0]             combo_status;

  modport source (output valid, output consumer_bits, output combo_status, input ready);
  modport sink   (input valid, input consumer_bits, input combo_status, output ready);
endinterface

`default_nettype wire

[design/bdr_lane.sv]
// ----------------------------------------------------------------------------
// bdr_lane
// One button: debounce, press event, and optional auto-repeat.
// ----------------------------------------------------------------------------
`default_nettype none

module bdr_lane
  import bdr_pkg::*;
#(
  parameter int TIME_BITS  = 32,
  parameter bit HAS_REPEAT = 1'b0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic                 raw,
  input  wire logic [TIME_BITS-1:0] t,
  input  wire cfg_t                 cfg,
  output logic                      evt
);

  localparam int CW = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

  logic                 stable, stable_next;
  logic                 raw_prev;
  logic [TIME_BITS-1:0] change_time, change_time_next;
  logic [TIME_BITS-1:0] press_time, press_time_next;
  logic [TIME_BITS-1:0] since_change;
  logic                 fire, new_press;

  always_comb begin
    change_time_next = (raw != raw_prev) ? t : change_time;
    // a fresh raw change restarts the timer at zero
    since_change     = (raw != raw_prev) ? '0 : t - change_time;
    fire             = (CW'(since_change) >= CW'(cfg.debounce_time)) && (stable != raw);
    stable_next      = fire ? raw : stable;
    new_press        = fire && raw;
    press_time_next  = new_press ? t : press_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable      <= 1'b0;
      raw_prev    <= 1'b0;
      change_time <= '0;
      press_time  <= '0;
    end else if (step) begin
      stable      <= stable_next;
      raw_prev    <= raw;
      change_time <= change_time_next;
      press_time  <= press_time_next;
    end
  end

  generate
    if (HAS_REPEAT) begin : g_rep
      logic [TIME_BITS-1:0] repeat_time, repeat_time_next, since_rep, held;
      logic                 rep_fire;

      always_comb begin
        held      = new_press ? '0 : t - press_time;
        since_rep = new_press ? '0 : t - repeat_time;
        rep_fire  = stable_next && (held != '0) &&
                    (CW'(held) >= CW'(cfg.repeat_delay)) &&
                    (CW'(since_rep) >= CW'(cfg.repeat_period));
        repeat_time_next = (new_press || rep_fire) ? t : repeat_time;
        evt = stable_next && ((held == '0) || rep_fire);
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          repeat_time <= '0;
        end else if (step) begin
          repeat_time <= repeat_time_next;
        end
      end
    end else begin : g_edge
      assign evt = stable_next && (press_time_next == t);
    end
  endgenerate

endmodule

`default_nettype wire

[design/bdr_combo.sv]
// ----------------------------------------------------------------------------
// bdr_combo
// Hold timer on the raw levels of both volume buttons.
// ----------------------------------------------------------------------------
`default_nettype none

module bdr_combo
  import bdr_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic                 both,
  input  wire logic [TIME_BITS-1:0] t,
  input  wire cfg_t                 cfg,
  output logic [1:0]                status
);

  localparam int CW = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

  logic                 active;
  logic [TIME_BITS-1:0] start, start_next, held;

  always_comb begin
    start_next = (both && !active) ? t : start;
    held       = t - start_next;
    status     = COMBO_NONE;
    if (both) begin
      if (CW'(held) >= CW'(cfg.reset_hold_time)) begin
        status = COMBO_RESET;
      end else if (CW'(held) >= CW'(cfg.pair_hold_time)) begin
        status = COMBO_PAIR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      start  <= '0;
    end else if (step) begin
      active <= both;
      start  <= start_next;
    end
  end

endmodule

`default_nettype wire

[design/button_debounce_repeat_combo.sv]
// ----------------------------------------------------------------------------
// button_debounce_repeat_combo
// Debounced button events with volume auto-repeat and a volume-combo timer.
// ----------------------------------------------------------------------------
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    raw_buttons, now_ms, host_ready
//   out_ch   out  valid/ready    consumer_bits, combo_status
//   cfg      in   cfg_we         cfg_index, cfg_wdata
//
// One scan tick per clock while in_ch.ready is high; its result is registered.
// All lanes and the combo timer update in the accepting cycle, so ticks can
// follow back to back.
// A two-entry output stage (result register plus skid) keeps in_ch.ready high
// until two results wait. Synchronous reset clears lane and combo state and the
// valid flags and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_repeat_combo
  import bdr_pkg::*;
#(
  parameter int NUM_BUTTONS = 6,
  parameter int TIME_BITS   = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  bdr_in_if.sink             in_ch,
  bdr_out_if.source          out_ch,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [CFG_BITS-1:0] cfg_wdata
);

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time   <= DEBOUNCE_TIME_RST;
      cfg.pair_hold_time  <= PAIR_HOLD_TIME_RST;
      cfg.reset_hold_time <= RESET_HOLD_TIME_RST;
      cfg.repeat_delay    <= REPEAT_DELAY_RST;
      cfg.repeat_period   <= REPEAT_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEBOUNCE_TIME:   cfg.debounce_time   <= cfg_wdata[15:0];
        REG_PAIR_HOLD_TIME:  cfg.pair_hold_time  <= cfg_wdata;
        REG_RESET_HOLD_TIME: cfg.reset_hold_time <= cfg_wdata;
        REG_REPEAT_DELAY:    cfg.repeat_delay    <= cfg_wdata[15:0];
        REG_REPEAT_PERIOD:   cfg.repeat_period   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic                   step;
  logic [TIME_BITS-1:0]   t;
  logic [NUM_BUTTONS-1:0] lane_evt;
  logic [1:0]             status;

  assign step = in_ch.valid && in_ch.ready;
  assign t    = TIME_BITS'(in_ch.now_ms);

  generate
    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      bdr_lane #(
        .TIME_BITS  (TIME_BITS),
        .HAS_REPEAT (i < 2)
      ) u_lane (
        .clk  (clk),
        .rst  (rst),
        .step (step),
        .raw  (in_ch.raw_buttons[i]),
        .t    (t),
        .cfg  (cfg),
        .evt  (lane_evt[i])
      );
    end
  endgenerate

  bdr_combo #(
    .TIME_BITS (TIME_BITS)
  ) u_combo (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .both   (in_ch.raw_buttons[1:0] == 2'b11),
    .t      (t),
    .cfg    (cfg),
    .status (status)
  );

  // merge: gate events by host link, pair with combo status
  logic [NUM_BUTTONS-1:0] new_bits;
  assign new_bits = in_ch.host_ready ? lane_evt : '0;

  logic                   out_valid, skid_valid;
  logic [NUM_BUTTONS-1:0] out_bits, skid_bits;
  logic [1:0]             out_status, skid_status;
  logic                   pop;

  assign pop         = out_valid && out_ch.ready;
  assign in_ch.ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_bits   <= skid_bits;
        out_status <= skid_status;
        skid_valid <= 1'b0;
      end else if (step) begin
        out_bits   <= new_bits;
        out_status <= status;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (step) begin
      if (!out_valid) begin
        out_bits   <= new_bits;
        out_status <= status;
        out_valid  <= 1'b1;
      end else begin
        skid_bits   <= new_bits;
        skid_status <= status;
        skid_valid  <= 1'b1;
      end
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.consumer_bits = out_bits;
  assign out_ch.combo_status  = out_status;

endmodule

`default_nettype wire

[tb/button_debounce_repeat_combo_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_repeat_combo_test
// Drives scan ticks into the debounce/repeat/combo block and checks every
// per-tick report against a typed row report or a cycle-free software model.
// A short directed table comes first, then random well-formed button sequences
// with bounce, repeated and wrapping timestamps, over several register settings.
// ----------------------------------------------------------------------------

module button_debounce_repeat_combo_test;
  import bdr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_TICKS = 160;

  typedef struct packed {
    logic [5:0] consumer_bits;
    logic [1:0] combo_status;
  } tick_report_t;

  typedef struct packed {
    logic [5:0]   raw;
    logic [31:0]  now;
    logic         host;
    logic         typed;
    tick_report_t report;
  } dir_row_t;

  // typed reports only where they follow directly from reset and the defaults
  localparam dir_row_t DIR_ROWS [24] = '{
    '{6'h00, 32'd0,     1'b1, 1'b1, '{6'h00, COMBO_NONE}},
    '{6'h3F, 32'd100,   1'b1, 1'b1, '{6'h00, COMBO_NONE}},
    '{6'h3F, 32'd115,   1'b0, 1'b1, '{6'h00, COMBO_NONE}},
    '{6'h3F, 32'd115,   1'b1, 1'b1, '{6'h3F, COMBO_NONE}},
    '{6'h3F, 32'd515,   1'b1, 1'b1, '{6'h03, COMBO_NONE}},
    '{6'h3F, 32'd600,   1'b1, 1'b1, '{6'h00, COMBO_NONE}},
    '{6'h3F, 32'd655,   1'b1, 1'b1, '{6'h03, COMBO_NONE}},
    '{6'h3F, 32'd3100,  1'b1, 1'b1, '{6'h03, COMBO_PAIR}},
    '{6'h3F, 32'd10100, 1'b1, 1'b1, '{6'h03, COMBO_RESET}},
    '{6'h3F, 32'd10100, 1'b0, 1'b1, '{6'h00, COMBO_RESET}},
    '{6'h3C, 32'd10101, 1'b1, 1'b0, '{6'h00, COMBO_NONE}},
    '{6'h3C, 32'd10116, 1'b1, 1'b0, '{6'h00, COMBO_NONE}},
    '{6'h00, 32'd10200, 1'b1, 1'b0, '{6'h00, COMBO_NONE}},
    '{6'h00, 32'd10215, 1'b1, 1'b0, '{6'h00, COMBO_NONE}},
    '{6'h04, 32'd10300, 1'b1, 1'b0, '{6'h00, COMBO_NONE}},
    '{6'h00, 32'd10305, 1'b1, 1'b0, '{6'h00, COMBO_NONE}},
    '{6'h04, 32'd10310, 1'b1, 1'b0, '{6'h00, COMBO_NONE}},
    '{6'h04, 32'd10324, 1'b1, 1'b0, '{6'h00, COMBO_NONE}},
    '{6'h04, 32'd10325, 1'b1, 1'b0, '{6'h00, COMBO_NONE}},
    '{6'h10, 32'hFFFF_FFFF, 1'b1, 1'b0, '{6'h00, COMBO_NONE}},
    '{6'h10, 32'd14,    1'b1, 1'b0, '{6'h00, COMBO_NONE}},
    '{6'h10, 32'd14,    1'b1, 1'b0, '{6'h00, COMBO_NONE}},
    '{6'h23, 32'd100,   1'b1, 1'b0, '{6'h00, COMBO_NONE}},
    '{6'h00, 32'd200,   1'b0, 1'b0, '{6'h00, COMBO_NONE}}
  };

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_wdata;

  bdr_in_if  #(.NUM_BUTTONS(6)) in_ch ();
  bdr_out_if #(.NUM_BUTTONS(6)) out_ch ();

  button_debounce_repeat_combo #(
    .NUM_BUTTONS(6),
    .TIME_BITS  (32)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // model state
  cfg_t        cfg_model;
  logic [5:0]  level;
  logic [5:0]  raw_seen;
  logic [31:0] chg_t   [6];
  logic [31:0] press_t [6];
  logic [31:0] rep_t   [2];
  logic [31:0] combo_t0;
  logic        combo_on;

  tick_report_t tick_reports_due [$];
  int          errors;
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          hold_off_req;
  bit          hold_off_taken;
  int          quiet_cycles;
  logic [5:0]  want_level;
  logic [31:0] now_acc;
  cfg_t        cfg_sets  [NUM_PHASES];
  int          tick_span [NUM_PHASES];

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [31:0] elapsed(logic [31:0] later, logic [31:0] since);
    return later - since;
  endfunction

  function automatic tick_report_t debounce_tick(logic [5:0] raw, logic [31:0] now,
                                                 logic host);
    tick_report_t rep;
    logic [5:0]   bits;
    logic [31:0]  held;
    int           i;
    bits = '0;
    rep.combo_status = COMBO_NONE;

    // combo runs on raw levels, ahead of debouncing
    if (raw[1:0] == 2'b11) begin
      if (!combo_on) begin
        combo_on = 1'b1;
        combo_t0 = now;
      end
      held = elapsed(now, combo_t0);
      if (held >= cfg_model.reset_hold_time) rep.combo_status = COMBO_RESET;
      else if (held >= cfg_model.pair_hold_time) rep.combo_status = COMBO_PAIR;
    end else begin
      combo_on = 1'b0;
    end

    for (i = 0; i < 6; i++) begin
      if (raw[i] != raw_seen[i]) begin
        raw_seen[i] = raw[i];
        chg_t[i] = now;
      end
      if (elapsed(now, chg_t[i]) >= {16'h0, cfg_model.debounce_time} &&
          level[i] != raw_seen[i]) begin
        level[i] = raw_seen[i];
        if (level[i]) begin
          press_t[i] = now;
          if (i < 2) rep_t[i] = now;
        end
      end
    end

    for (i = 0; i < 2; i++) begin
      if (level[i]) begin
        held = elapsed(now, press_t[i]);
        if (held == 0) begin
          bits[i] = 1'b1;
        end else if (held >= {16'h0, cfg_model.repeat_delay} &&
                     elapsed(now, rep_t[i]) >= {16'h0, cfg_model.repeat_period}) begin
          rep_t[i] = now;
          bits[i] = 1'b1;
        end
      end
    end

    // press event repeats on every tick whose time equals the press time
    for (i = 2; i < 6; i++) begin
      if (level[i] && press_t[i] == now) bits[i] = 1'b1;
    end

    rep.consumer_bits = host ? bits : 6'h00;
    return rep;
  endfunction

  task automatic send_tick(logic [5:0] raw, logic [31:0] now, logic host, logic typed,
                           tick_report_t typed_report);
    tick_report_t rep;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.raw_buttons <= raw;
    in_ch.now_ms      <= now;
    in_ch.host_ready  <= host;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    rep = debounce_tick(raw, now, host);
    tick_reports_due.push_back(typed ? typed_report : rep);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // sender stays quiet until every report is back, then writes all registers
  task automatic load_cfg(cfg_t c);
    while (tick_reports_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    write_reg(REG_DEBOUNCE_TIME,   32'(c.debounce_time));
    write_reg(REG_PAIR_HOLD_TIME,  c.pair_hold_time);
    write_reg(REG_RESET_HOLD_TIME, c.reset_hold_time);
    write_reg(REG_REPEAT_DELAY,    32'(c.repeat_delay));
    write_reg(REG_REPEAT_PERIOD,   32'(c.repeat_period));
    cfg_we <= 1'b0;
    cfg_model = c;
  endtask

  task automatic run_phase(int count, int span);
    logic [5:0]  raw;
    logic [31:0] step;
    int          roll;
    int          bounce;
    bounce = 0;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        want_level ^= 6'h01 << $urandom_range(5);
        bounce = $urandom_range(4);
      end else if (roll < 6) begin
        want_level[1:0] = (want_level[1:0] == 2'b11) ? 2'b00 : 2'b11;
        bounce = $urandom_range(4);
      end else if (roll < 7) begin
        want_level = 6'($urandom_range(63));
      end
      raw = want_level;
      if (bounce > 0) begin
        if ($urandom_range(1) == 1) raw ^= 6'h01 << $urandom_range(5);
        bounce--;
      end
      if ($urandom_range(99) < 5) raw = 6'($urandom_range(63));

      roll = $urandom_range(99);
      if (roll < 10) step = 0;
      else if (roll < 80) step = $urandom_range(span, 1);
      else if (roll < 95) step = $urandom_range(16 * span, 0);
      else if (roll < 99) step = $urandom_range(70000, 0);
      else step = $urandom;
      now_acc += step;
      send_tick(raw, now_acc, $urandom_range(99) < 85, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_taken) begin
        hold_off_taken = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : report_check
    tick_report_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (tick_reports_due.size() == 0) begin
        $error("unexpected report: consumer_bits=%h combo_status=%0d",
               out_ch.consumer_bits, out_ch.combo_status);
        errors++;
      end else begin
        want = tick_reports_due.pop_front();
        if (out_ch.consumer_bits !== want.consumer_bits) begin
          $error("consumer_bits: expected %h, actual %h",
                 want.consumer_bits, out_ch.consumer_bits);
          errors++;
        end
        if (out_ch.combo_status !== want.combo_status) begin
          $error("combo_status: expected %0d, actual %0d",
                 want.combo_status, out_ch.combo_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** button_debounce_repeat_combo: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int p;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = REG_DEBOUNCE_TIME;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.raw_buttons = '0;
    in_ch.now_ms      = '0;
    in_ch.host_ready  = 1'b0;
    errors            = 0;
    hold_off_req      = 1'b0;
    hold_off_taken    = 1'b0;
    tx_idle_pct       = 37;
    rx_idle_pct       = 45;
    want_level        = '0;
    now_acc           = 32'd200;

    cfg_model = '{DEBOUNCE_TIME_RST, PAIR_HOLD_TIME_RST, RESET_HOLD_TIME_RST,
                  REPEAT_DELAY_RST, REPEAT_PERIOD_RST};
    level    = '0;
    raw_seen = '0;
    for (p = 0; p < 6; p++) begin
      chg_t[p]   = '0;
      press_t[p] = '0;
    end
    rep_t[0] = '0;
    rep_t[1] = '0;
    combo_t0 = '0;
    combo_on = 1'b0;

    cfg_sets[0] = '{16'd15, 32'd3000, 32'd10000, 16'd400, 16'd140};
    cfg_sets[1] = '{16'd0, 32'd0, 32'd0, 16'd0, 16'd0};
    cfg_sets[2] = '{16'd5, 32'd300, 32'd900, 16'd60, 16'd20};
    cfg_sets[3] = '{16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF};
    cfg_sets[4] = '{16'd10, 32'd500, 32'd200, 16'd30, 16'd0};   // reset below pair
    cfg_sets[5] = '{16'd1, 32'd1, 32'd2, 16'd1, 16'd1};
    cfg_sets[6] = '{16'($urandom_range(40)), 32'($urandom_range(2000)),
                    32'($urandom_range(4000)), 16'($urandom_range(300)),
                    16'($urandom_range(100))};
    cfg_sets[7] = '{16'd0, 32'd100, 32'd100, 16'hFFFF, 16'd0};
    tick_span = '{40, 5, 25, 30000, 20, 3, 30, 50};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[r])
      send_tick(DIR_ROWS[r].raw, DIR_ROWS[r].now, DIR_ROWS[r].host, DIR_ROWS[r].typed,
                DIR_ROWS[r].report);
    in_ch.valid <= 1'b0;

    for (p = 0; p < NUM_PHASES; p++) begin
      load_cfg(cfg_sets[p]);
      if (p < 3) begin
        tx_idle_pct = 37;
        rx_idle_pct = 45;
      end else if (p < 6) begin
        tx_idle_pct = 45;
        rx_idle_pct = 37;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // long receiver hold-off while ticks keep coming
      if (p == 2) hold_off_req = 1'b1;
      run_phase(PHASE_TICKS, tick_span[p]);
    end

    while (tick_reports_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("** button_debounce_repeat_combo: PASSED **");
    end else begin
      $display("** button_debounce_repeat_combo: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
design/bdr_pkg.sv
design/bdr_if.sv
design/bdr_lane.sv
design/bdr_combo.sv
design/button_debounce_repeat_combo.sv
tb/button_debounce_repeat_combo_test.sv
